### design/tcgr_pkg.sv
// Shared types and constants of the text console glyph renderer.
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

   // Default sizes, handed to the top level parameters
   localparam int MAX_COLUMNS_DEF = 256;
   localparam int MAX_ROWS_DEF    = 128;
   localparam int GLYPH_COUNT_DEF = 128;

   // Fixed cell geometry: 8x8 pixels
   localparam int CELL_SIZE       = 8;
   localparam int CELL_PIXELS     = CELL_SIZE * CELL_SIZE;
   localparam int PIX_CNT_W       = 6;

   // Character codes
   localparam logic [7:0] CODE_LIMIT = 8'd128;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   // Function codes of an input item
   localparam logic FUNC_RENDER = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   // Register reset values
   localparam logic [31:0] FG_RESET   = 32'hD3D7CF;
   localparam logic [31:0] BG_RESET   = 32'h0;
   localparam logic [8:0]  COLS_RESET = 9'd256;
   localparam logic [7:0]  ROWS_RESET = 8'd128;

   // Register map, one word per register
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_FG   = 2'd0,
      CSR_BG   = 2'd1,
      CSR_COLS = 2'd2,
      CSR_ROWS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       func;
      logic [7:0] char_code;
      logic [2:0] glyph_row;
      logic [7:0] glyph_bits;
   } req_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [10:0] pixel_x;
      logic [9:0]  pixel_y;
      logic [31:0] pixel_color;
      logic        scroll_request;
      logic        last_of_run;
   } rsp_type;

   // What the cursor unit tells the raster about one character
   typedef struct packed {
      logic draw;
      logic scroll;
   } cell_flags_type;

endpackage

`default_nettype wire

### design/text_console_glyph_renderer.sv
// Top level: register port, input steering, cursor unit and pixel pipeline.
// The first pixel transfer of a character passes the job stage and the select stage to the output register.
// A drawn character gives 64 pixels, one pixel per cycle from the glyph store read port while rsp_ready holds.
// Newline and undrawable codes give one result without a pixel; font loads give no result.
// A font load to the glyph being drawn waits until its last row has been read.
// Reset clears the cursor, the pipeline and the registers; the glyph store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module text_console_glyph_renderer #(
   parameter int MAX_COLUMNS = tcgr_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = tcgr_pkg::MAX_ROWS_DEF,
   parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // character input
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire tcgr_pkg::req_type               req_data,
   // pixel results
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output tcgr_pkg::rsp_type                    rsp_data,
   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tcgr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic      [31:0]                     csr_prdata,
   output logic                                 csr_pready
);

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

   logic [31:0] fg_ff, fg_in;
   logic [31:0] bg_ff, bg_in;
   logic [8:0]  cols_ff, cols_in;
   logic [7:0]  rows_ff, rows_in;

   tcgr_pkg::csr_index_type csr_index;
   logic                    csr_write;

   logic                     req_xfer, start, load;
   logic                     job_free, load_block;
   logic [COL_W-1:0]         cell_col;
   logic [ROW_W-1:0]         cell_row;
   logic [7:0]               cell_glyph;
   tcgr_pkg::cell_flags_type cell_flags;

   // Register port: write on the access phase, read back any time
   assign csr_pready = 1'b1;
   assign csr_index  = tcgr_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      fg_in   = fg_ff;
      bg_in   = bg_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      csr_prdata = '0;
      case (csr_index)
         tcgr_pkg::CSR_FG: begin
            csr_prdata = fg_ff;
            if (csr_write) fg_in = csr_pwdata;
         end
         tcgr_pkg::CSR_BG: begin
            csr_prdata = bg_ff;
            if (csr_write) bg_in = csr_pwdata;
         end
         tcgr_pkg::CSR_COLS: begin
            csr_prdata = 32'(cols_ff);
            if (csr_write) cols_in = csr_pwdata[8:0];
         end
         tcgr_pkg::CSR_ROWS: begin
            csr_prdata = 32'(rows_ff);
            if (csr_write) rows_in = csr_pwdata[7:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff   <= tcgr_pkg::FG_RESET;
         bg_ff   <= tcgr_pkg::BG_RESET;
         cols_ff <= tcgr_pkg::COLS_RESET;
         rows_ff <= tcgr_pkg::ROWS_RESET;
      end else begin
         fg_ff   <= fg_in;
         bg_ff   <= bg_in;
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // Renders wait for a free job slot; font loads only for a glyph not being read.
   // Loads beyond the glyph count are taken and dropped.
   assign req_ready = (req_data.func == tcgr_pkg::FUNC_LOAD) ? ~load_block : job_free;
   assign req_xfer  = req_valid & req_ready;
   assign start     = req_xfer & (req_data.func == tcgr_pkg::FUNC_RENDER);
   assign load      = req_xfer & (req_data.func == tcgr_pkg::FUNC_LOAD) &
                      ({1'b0, req_data.char_code} < GLYPH_LIMIT);

   // Cursor moves at accept; the raster works from the captured cell
   tcgr_cursor #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_cursor (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .char_code    (req_data.char_code),
      .text_columns (cols_ff),
      .text_rows    (rows_ff),
      .cell_col     (cell_col),
      .cell_row     (cell_row),
      .cell_glyph   (cell_glyph),
      .cell_flags   (cell_flags)
   );

   tcgr_raster #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_col   (cell_col),
      .start_row   (cell_row),
      .start_glyph (cell_glyph),
      .start_flags (cell_flags),
      .job_free    (job_free),
      .load        (load),
      .load_glyph  (req_data.char_code),
      .load_row    (req_data.glyph_row),
      .load_bits   (req_data.glyph_bits),
      .load_block  (load_block),
      .ink_color   (fg_ff),
      .paper_color (bg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

### design/tcgr_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                     wdata,
   input  wire logic                                 re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### design/tcgr_cursor.sv
// Text cursor: clamps to the screen, classifies the character and advances.
`timescale 1ns / 1ps
`default_nettype none

module tcgr_cursor #(
   parameter int MAX_COLUMNS = tcgr_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = tcgr_pkg::MAX_ROWS_DEF,
   parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [7:0]            char_code,
   input  wire logic [8:0]            text_columns,
   input  wire logic [7:0]            text_rows,
   output logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] cell_col,
   output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0]       cell_row,
   output logic [7:0]                 cell_glyph,
   output tcgr_pkg::cell_flags_type   cell_flags
);

   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COLS_W-1:0] cols_c, col_sat, col_nx;
   logic [ROWS_W-1:0] rows_c, row_sat, row_nx;
   logic              scroll;
   logic [7:0]        glyph;

   // Saturate screen size to 1..MAX
   always_comb begin
      if (text_columns == '0) begin
         cols_c = COLS_W'(1);
      end else if (32'(text_columns) > MAX_COLUMNS) begin
         cols_c = COLS_W'(MAX_COLUMNS);
      end else begin
         cols_c = COLS_W'(text_columns);
      end
      if (text_rows == '0) begin
         rows_c = ROWS_W'(1);
      end else if (32'(text_rows) > MAX_ROWS) begin
         rows_c = ROWS_W'(MAX_ROWS);
      end else begin
         rows_c = ROWS_W'(text_rows);
      end
   end

   always_comb begin
      col_sat = COLS_W'(cur_col_ff);
      row_sat = ROWS_W'(cur_row_ff);
      if (col_sat >= cols_c) begin
         col_sat = cols_c - COLS_W'(1);
      end
      if (row_sat >= rows_c) begin
         row_sat = rows_c - ROWS_W'(1);
      end

      if (char_code == tcgr_pkg::CH_NEWLINE) begin
         col_nx = '0;
         row_nx = row_sat + ROWS_W'(1);
      end else begin
         col_nx = col_sat + COLS_W'(1);
         row_nx = row_sat;
      end
      if (col_nx >= cols_c) begin
         col_nx = '0;
         row_nx = row_sat + ROWS_W'(1);
      end
      scroll = 1'b0;
      if (row_nx >= rows_c) begin
         scroll = 1'b1;
         row_nx = rows_c - ROWS_W'(1);
      end

      glyph = (char_code == tcgr_pkg::CH_TAB) ? tcgr_pkg::CH_SPACE : char_code;
      cell_flags.draw   = (char_code != tcgr_pkg::CH_NEWLINE) &&
                          (glyph < tcgr_pkg::CODE_LIMIT) &&
                          ({1'b0, glyph} < GLYPH_LIMIT);
      cell_flags.scroll = scroll;
      cell_glyph = glyph;
      cell_col   = COL_W'(col_sat);
      cell_row   = ROW_W'(row_sat);

      cur_col_in = start ? COL_W'(col_nx) : cur_col_ff;
      cur_row_in = start ? ROW_W'(row_nx) : cur_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

endmodule

`default_nettype wire

### design/tcgr_raster.sv
// Glyph store and pixel pipeline: row read, pixel select, output register.
`timescale 1ns / 1ps
`default_nettype none

module tcgr_raster #(
   parameter int MAX_COLUMNS = tcgr_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = tcgr_pkg::MAX_ROWS_DEF,
   parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // new character job
   input  wire logic                start,
   input  wire logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] start_col,
   input  wire logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0]       start_row,
   input  wire logic [7:0]          start_glyph,
   input  wire tcgr_pkg::cell_flags_type start_flags,
   output logic                     job_free,
   // font load
   input  wire logic                load,
   input  wire logic [7:0]          load_glyph,
   input  wire logic [2:0]          load_row,
   input  wire logic [7:0]          load_bits,
   output logic                     load_block,
   // colors
   input  wire logic [31:0]         ink_color,
   input  wire logic [31:0]         paper_color,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output tcgr_pkg::rsp_type        rsp_data
);

   localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int GS_DEPTH  = GLYPH_COUNT * tcgr_pkg::CELL_SIZE;
   localparam int GS_ADDR_W = $clog2(GS_DEPTH);
   localparam int CNT_W     = tcgr_pkg::PIX_CNT_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tcgr_pkg::CELL_PIXELS - 1);

   // job stage: walks the 64 pixels and issues the row reads
   logic                     job_valid_ff, job_valid_in;
   logic [CNT_W-1:0]         job_cnt_ff, job_cnt_in;
   logic [COL_W-1:0]         job_col_ff, job_col_in;
   logic [ROW_W-1:0]         job_row_ff, job_row_in;
   logic [7:0]               job_glyph_ff, job_glyph_in;
   tcgr_pkg::cell_flags_type job_flags_ff, job_flags_in;

   // select stage: aligned with the glyph row read data
   logic                     s2_valid_ff, s2_valid_in;
   logic [10:0]              s2_x_ff, s2_x_in;
   logic [9:0]               s2_y_ff, s2_y_in;
   logic [2:0]               s2_xi_ff, s2_xi_in;
   logic                     s2_draw_ff, s2_draw_in;
   logic                     s2_scroll_ff, s2_scroll_in;
   logic                     s2_last_ff, s2_last_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   tcgr_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     s1_adv, s2_adv, s2_free, job_end;
   logic [GS_ADDR_W-1:0]     raddr, waddr;
   logic                     ren;
   logic [7:0]               row_bits;

   assign s2_adv  = s2_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign s2_free = ~s2_valid_ff | s2_adv;
   assign s1_adv  = job_valid_ff & s2_free;
   assign job_end = (job_cnt_ff == CNT_LAST) | ~job_flags_ff.draw;
   assign job_free = ~job_valid_ff | (s1_adv & job_end);

   // hold font loads to a glyph whose rows are still to be read
   assign load_block = job_valid_ff & job_flags_ff.draw & (job_glyph_ff == load_glyph);

   assign raddr = GS_ADDR_W'({job_glyph_ff, job_cnt_ff[CNT_W-1:3]});
   assign ren   = s1_adv & job_flags_ff.draw;
   assign waddr = GS_ADDR_W'({load_glyph, load_row});

   tcgr_ram #(
      .WIDTH (tcgr_pkg::CELL_SIZE),
      .DEPTH (GS_DEPTH)
   ) u_glyph_store (
      .clock (clock),
      .we    (load),
      .waddr (waddr),
      .wdata (load_bits),
      .re    (ren),
      .raddr (raddr),
      .rdata (row_bits)
   );

   always_comb begin
      job_valid_in = job_valid_ff;
      job_cnt_in   = job_cnt_ff;
      job_col_in   = job_col_ff;
      job_row_in   = job_row_ff;
      job_glyph_in = job_glyph_ff;
      job_flags_in = job_flags_ff;
      if (start) begin
         job_valid_in = 1'b1;
         job_cnt_in   = '0;
         job_col_in   = start_col;
         job_row_in   = start_row;
         job_glyph_in = start_glyph;
         job_flags_in = start_flags;
      end else if (s1_adv && job_end) begin
         job_valid_in = 1'b0;
      end else if (s1_adv) begin
         job_cnt_in = job_cnt_ff + CNT_W'(1);
      end

      s2_valid_in  = s2_adv ? 1'b0 : s2_valid_ff;
      s2_x_in      = s2_x_ff;
      s2_y_in      = s2_y_ff;
      s2_xi_in     = s2_xi_ff;
      s2_draw_in   = s2_draw_ff;
      s2_scroll_in = s2_scroll_ff;
      s2_last_in   = s2_last_ff;
      if (s1_adv) begin
         s2_valid_in  = 1'b1;
         s2_x_in      = 11'({job_col_ff, job_cnt_ff[2:0]});
         s2_y_in      = 10'({job_row_ff, job_cnt_ff[CNT_W-1:3]});
         s2_xi_in     = job_cnt_ff[2:0];
         s2_draw_in   = job_flags_ff.draw;
         s2_scroll_in = job_flags_ff.scroll;
         s2_last_in   = job_end;
      end

      rsp_valid_in = (rsp_valid_ff & ~rsp_ready) | s2_adv;
      rsp_data_in  = rsp_data_ff;
      if (s2_adv) begin
         rsp_data_in.pixel_valid    = s2_draw_ff;
         rsp_data_in.pixel_x        = s2_draw_ff ? s2_x_ff : '0;
         rsp_data_in.pixel_y        = s2_draw_ff ? s2_y_ff : '0;
         rsp_data_in.pixel_color    = !s2_draw_ff ? '0 :
                                      (row_bits[s2_xi_ff] ? ink_color : paper_color);
         rsp_data_in.scroll_request = s2_last_ff & s2_scroll_ff;
         rsp_data_in.last_of_run    = s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_cnt_ff   <= job_cnt_in;
      job_col_ff   <= job_col_in;
      job_row_ff   <= job_row_in;
      job_glyph_ff <= job_glyph_in;
      job_flags_ff <= job_flags_in;
      s2_x_ff      <= s2_x_in;
      s2_y_ff      <= s2_y_in;
      s2_xi_ff     <= s2_xi_in;
      s2_draw_ff   <= s2_draw_in;
      s2_scroll_ff <= s2_scroll_in;
      s2_last_ff   <= s2_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a glyph row is never rewritten in the cycle it is read for a pending pixel
   a_no_rw_same_row: assert property (@(posedge clock) disable iff (reset)
      (load && ren) |-> (waddr != raddr))
      else $error("glyph store write collides with pending row read");

   // a non-drawing job retires after its single result
   a_nodraw_single: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && !job_flags_ff.draw) |-> (job_cnt_ff == '0))
      else $error("non-drawing job advanced its pixel counter");

   // scroll request only rides on the closing result
   a_scroll_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.scroll_request) |-> rsp_data_ff.last_of_run)
      else $error("scroll request outside the last result");

   // a result without a pixel always closes its character
   a_nopix_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.pixel_valid) |-> rsp_data_ff.last_of_run)
      else $error("pixel-less result does not close its character");

endmodule

`default_nettype wire

### sim/text_console_glyph_renderer_tb.sv
// Testbench of the text console glyph renderer: font loads, character kinds, cursor and pixels.
`timescale 1ns / 1ps

module text_console_glyph_renderer_tb;

   // Screen and font sizes of the instance under test (top level defaults)
   localparam int SCREEN_COLS = tcgr_pkg::MAX_COLUMNS_DEF;
   localparam int SCREEN_ROWS = tcgr_pkg::MAX_ROWS_DEF;
   localparam int GLYPHS      = tcgr_pkg::GLYPH_COUNT_DEF;
   localparam int CELL        = tcgr_pkg::CELL_SIZE;

   // Quiet cycles allowed before the run is declared hung; the longest legal
   // gap is a random stall of either side, far below this.
   localparam int STALL_LIMIT   = 3000;
   // Cycles to hold after the last pixel before a register write or the end
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tcgr_pkg::req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tcgr_pkg::rsp_type rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [tcgr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_console_glyph_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // ------------------------------------------------------------------
   // Predicted block state: registers, text cursor and glyph store.
   // ------------------------------------------------------------------
   logic [31:0] ink_color   = tcgr_pkg::FG_RESET;
   logic [31:0] paper_color = tcgr_pkg::BG_RESET;
   logic [8:0]  cols_reg = tcgr_pkg::COLS_RESET;
   logic [7:0]  rows_reg = tcgr_pkg::ROWS_RESET;
   int unsigned cursor_col = 0;
   int unsigned cursor_row = 0;
   logic [7:0]  font_bytes  [0:GLYPHS*CELL-1];
   bit          row_written [0:GLYPHS*CELL-1];

   // Pixel writes still owed by the block, oldest first
   tcgr_pkg::rsp_type pending_pixels[$];

   int mismatch_count  = 0;
   int items_sent      = 0;
   int source_idle_pct = 33;
   int sink_idle_pct   = 84;

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: apply one accepted transfer to the state and queue the
   // pixel writes it must produce.
   // ------------------------------------------------------------------
   task automatic predict_glyph_writes(input tcgr_pkg::req_type item);
      int unsigned       cols, rows, glyph, col, row, slot;
      bit                draw, scroll;
      tcgr_pkg::rsp_type px;
      if (item.func == tcgr_pkg::FUNC_LOAD) begin
         // Glyph numbers past the store are dropped without effect
         if (item.char_code < GLYPHS) begin
            slot = item.char_code * CELL + item.glyph_row;
            font_bytes[slot]  = item.glyph_bits;
            row_written[slot] = 1'b1;
         end
         return;
      end
      // Clamp the screen size, then pull the cursor back on screen if it shrank
      cols = (cols_reg == 0) ? 1 : (cols_reg > SCREEN_COLS) ? SCREEN_COLS : cols_reg;
      rows = (rows_reg == 0) ? 1 : (rows_reg > SCREEN_ROWS) ? SCREEN_ROWS : rows_reg;
      if (cursor_col >= cols) cursor_col = cols - 1;
      if (cursor_row >= rows) cursor_row = rows - 1;
      col = cursor_col;
      row = cursor_row;
      // Tab draws the space glyph; newline and high codes draw nothing
      glyph = (item.char_code == tcgr_pkg::CH_TAB) ? tcgr_pkg::CH_SPACE : item.char_code;
      draw  = (item.char_code != tcgr_pkg::CH_NEWLINE) &&
              (glyph < tcgr_pkg::CODE_LIMIT) && (glyph < GLYPHS);
      scroll = 1'b0;
      if (item.char_code == tcgr_pkg::CH_NEWLINE) begin
         cursor_col = 0;
         cursor_row++;
      end else begin
         cursor_col++;
      end
      if (cursor_col >= cols) begin
         cursor_col = 0;
         cursor_row++;
      end
      // Past the bottom: ask for a one-row scroll and stay on the last row
      if (cursor_row >= rows) begin
         scroll     = 1'b1;
         cursor_row = rows - 1;
      end
      if (draw) begin
         for (int y = 0; y < CELL; y++) begin
            for (int x = 0; x < CELL; x++) begin
               px.pixel_valid    = 1'b1;
               px.pixel_x        = 11'(col * CELL + x);
               px.pixel_y        = 10'(row * CELL + y);
               px.pixel_color    = font_bytes[glyph * CELL + y][x] ? ink_color
                                                                   : paper_color;
               px.last_of_run    = (y == CELL - 1) && (x == CELL - 1);
               px.scroll_request = px.last_of_run && scroll;
               pending_pixels.push_back(px);
            end
         end
      end else begin
         px                = '0;
         px.scroll_request = scroll;
         px.last_of_run    = 1'b1;
         pending_pixels.push_back(px);
      end
   endtask

   function automatic bit glyph_complete(input int unsigned glyph);
      for (int r = 0; r < CELL; r++)
         if (!row_written[glyph * CELL + r]) return 1'b0;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------

   // Offer one transfer, idling beforehand at the current rate. Valid stays
   // high after the accept; the next call either replaces the payload or
   // drops valid at the following falling edge.
   task automatic send_item(input tcgr_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(99) < source_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_glyph_writes(item);
      if (!(item.func == tcgr_pkg::FUNC_LOAD && item.char_code >= GLYPHS)) items_sent++;
   endtask

   task automatic send_font_row(input logic [7:0] code, input logic [2:0] row,
                                input logic [7:0] bits);
      tcgr_pkg::req_type item;
      item.func       = tcgr_pkg::FUNC_LOAD;
      item.char_code  = code;
      item.glyph_row  = row;
      item.glyph_bits = bits;
      send_item(item);
   endtask

   // Render one character; fill in its glyph first if any row is still unset,
   // so the store is never read where it was not written.
   task automatic send_char(input logic [7:0] code);
      tcgr_pkg::req_type item;
      int unsigned       glyph;
      glyph = (code == tcgr_pkg::CH_TAB) ? tcgr_pkg::CH_SPACE : code;
      if (code != tcgr_pkg::CH_NEWLINE && glyph < tcgr_pkg::CODE_LIMIT && glyph < GLYPHS &&
          !glyph_complete(glyph))
         for (int r = 0; r < CELL; r++)
            send_font_row(8'(glyph), 3'(r), 8'($urandom));
      item.func       = tcgr_pkg::FUNC_RENDER;
      item.char_code  = code;
      item.glyph_row  = 3'($urandom);
      item.glyph_bits = 8'($urandom);
      send_item(item);
   endtask

   // Drop valid and wait until every owed pixel has arrived
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register port: setup cycle, then access cycle, only while idle
   // ------------------------------------------------------------------
   task automatic write_register(input tcgr_pkg::csr_index_type idx,
                                 input logic [31:0] value);
      settle_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         tcgr_pkg::CSR_FG:   ink_color   = value;
         tcgr_pkg::CSR_BG:   paper_color = value;
         tcgr_pkg::CSR_COLS: cols_reg    = value[8:0];
         tcgr_pkg::CSR_ROWS: rows_reg    = value[7:0];
         default:            ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_screen(input logic [31:0] fg, input logic [31:0] bg,
                             input logic [8:0] cols, input logic [7:0] rows);
      write_register(tcgr_pkg::CSR_FG, fg);
      write_register(tcgr_pkg::CSR_BG, bg);
      write_register(tcgr_pkg::CSR_COLS, {23'd0, cols});
      write_register(tcgr_pkg::CSR_ROWS, {24'd0, rows});
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls, and a field-by-field check of each
   // pixel transfer against the oldest owed one.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : pixel_check
      tcgr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: pixel transfer with nothing owed, expected none, got %p",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_valid",    want.pixel_valid,    rsp_data.pixel_valid);
            check_field("pixel_x",        want.pixel_x,        rsp_data.pixel_x);
            check_field("pixel_y",        want.pixel_y,        rsp_data.pixel_y);
            check_field("pixel_color",    want.pixel_color,    rsp_data.pixel_color);
            check_field("scroll_request", want.scroll_request, rsp_data.scroll_request);
            check_field("last_of_run",    want.last_of_run,    rsp_data.last_of_run);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run once nothing has moved for too long
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Load the space glyph with edge patterns and glyph 127 bottom-up, then
   // try loads past the store: they alias onto row 3 of the space glyph and
   // row 7 of glyph 127, so a block that keeps them corrupts those glyphs.
   task automatic test_glyph_loads();
      logic [7:0] space_rows [0:7];
      space_rows = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0};
      for (int r = 0; r < CELL; r++)
         send_font_row(tcgr_pkg::CH_SPACE, 3'(r), space_rows[r]);
      for (int r = CELL - 1; r >= 0; r--)
         send_font_row(8'd127, 3'(r), 8'($urandom));
      send_font_row(tcgr_pkg::CODE_LIMIT + tcgr_pkg::CH_SPACE, 3'd3, 8'h5A);
      send_font_row(8'hFF, 3'd7, 8'hFF);
   endtask

   // One of each kind: space, tab, top glyph, newline, lowest and highest
   // undrawable codes
   task automatic test_character_kinds();
      send_char(tcgr_pkg::CH_SPACE);
      send_char(tcgr_pkg::CH_TAB);
      send_char(8'd127);
      send_char(tcgr_pkg::CH_NEWLINE);
      send_char(tcgr_pkg::CODE_LIMIT);
      send_char(8'hFF);
   endtask

   // Shrink to a single cell with the cursor off screen: every character
   // then wraps and scrolls
   task automatic test_wrap_and_scroll();
      write_register(tcgr_pkg::CSR_COLS, 32'd1);
      write_register(tcgr_pkg::CSR_ROWS, 32'd1);
      send_char(8'd127);
      send_char(tcgr_pkg::CH_NEWLINE);
      send_char(8'd200);
   endtask

   function automatic logic [7:0] pick_loaded_glyph();
      int found[$];
      for (int g = 0; g < GLYPHS; g++)
         if (g != tcgr_pkg::CH_NEWLINE && glyph_complete(g)) found.push_back(g);
      return 8'(found[$urandom_range(found.size() - 1)]);
   endfunction

   // Mostly characters of fully loaded glyphs with random content, new
   // glyphs loaded on the fly, plus stray row reloads (some hitting the
   // glyph on screen, some past the store), control and high codes.
   task automatic test_random_traffic(input int source_pct, input int sink_pct,
                                      input int count);
      int         first;
      int         pick;
      logic [7:0] code;
      first           = items_sent;
      source_idle_pct = source_pct;
      sink_idle_pct   = sink_pct;
      while (items_sent - first < count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            code = (pick < 3) ? 8'($urandom_range(255, tcgr_pkg::CODE_LIMIT))
                              : pick_loaded_glyph();
            send_font_row(code, 3'($urandom), 8'($urandom));
         end else if (pick < 30) begin
            case ($urandom_range(3))
               0:       code = tcgr_pkg::CH_NEWLINE;
               1:       code = tcgr_pkg::CH_TAB;
               default: code = 8'($urandom_range(255, tcgr_pkg::CODE_LIMIT));
            endcase
            send_char(code);
         end else if (pick < 70) begin
            send_char(pick_loaded_glyph());
         end else begin
            send_char(8'($urandom_range(tcgr_pkg::CODE_LIMIT - 1)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, slow receiver
      test_glyph_loads();
      test_character_kinds();
      test_wrap_and_scroll();

      // Oversized width and zero height both clamp; full-scale colors
      set_screen(32'hFFFF_FFFF, 32'h0, 9'd511, 8'd0);
      test_random_traffic(33, 84, 28);

      // Tiny screen so wraps and scrolls come often; slow sender
      set_screen($urandom, $urandom, 9'($urandom_range(12, 1)), 8'($urandom_range(6, 1)));
      test_random_traffic(84, 33, 28);

      // Oversized height clamps; colors swapped to the other extremes; no idling
      set_screen(32'h0, 32'hFFFF_FFFF, 9'($urandom_range(40, 2)), 8'd255);
      test_random_traffic(0, 0, 27);

      // Drain, then hold a little longer to catch stray transfers
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
